[design/wpc_pkg.sv]
// Shared types and constants for the WAV PCM16 chunk parser.
package wpc_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;
	localparam logic [31:0] FMT_FIXED_LEN = 32'd16;
	localparam logic [15:0] FMT_PCM = 16'd1;
	localparam logic [15:0] PCM_BITS = 16'd16;
	localparam logic [5:0]  DIV_STEPS = 6'd32;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_NO_RIFF     = 4'd1,
		ST_NO_WAVE     = 4'd2,
		ST_FMT_SMALL   = 4'd3,
		ST_TRUNCATED   = 4'd4,
		ST_MISSING     = 4'd5,
		ST_UNSUPPORTED = 4'd6,
		ST_BAD_FORMAT  = 4'd7,
		ST_UNALIGNED   = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		PH_HEAD  = 3'd0,
		PH_CHUNK = 3'd1,
		PH_FMT   = 3'd2,
		PH_SKIP  = 3'd3,
		PH_DATA  = 3'd4,
		PH_PAD   = 3'd5,
		PH_DONE  = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		C_IDLE   = 3'd0,
		C_CHECK  = 3'd1,
		C_SAMPLE = 3'd2,
		C_EVAL   = 3'd3,
		C_DIV    = 3'd4,
		C_STATUS = 3'd5
	} ctrl_state_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic signed [15:0] sample;
		logic        chunk_start;
		logic [3:0]  status;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [15:0] sample_bits;
		logic [30:0] frame_count;
		logic        final_res;
	} out_item_t;

	typedef struct packed {
		logic step;
		logic eval;
		logic div_start;
		logic clear;
		logic show_status;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic eof;
		logic need_div;
		logic div_done;
	} stat_t;

endpackage

[design/wpc_ctrl.sv]
// Handshake and sequencing controller for the WAV PCM16 chunk parser.
module wpc_ctrl import wpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			C_IDLE: begin
				if (in_valid) state_d = C_CHECK;
			end
			C_CHECK: begin
				if (stat.emit) state_d = C_SAMPLE;
				else if (stat.eof) state_d = C_EVAL;
				else state_d = C_IDLE;
			end
			C_SAMPLE: begin
				if (out_ready) state_d = stat.eof ? C_EVAL : C_IDLE;
			end
			C_EVAL: begin
				state_d = stat.need_div ? C_DIV : C_STATUS;
			end
			C_DIV: begin
				if (stat.div_done) state_d = C_STATUS;
			end
			C_STATUS: begin
				if (out_ready) state_d = C_IDLE;
			end
			default: state_d = C_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		case (state_q)
			C_IDLE: begin
				in_ready = 1'b1;
				cmd.step = in_valid;
			end
			C_SAMPLE: begin
				out_valid = 1'b1;
			end
			C_EVAL: begin
				cmd.eval = 1'b1;
				cmd.div_start = stat.need_div;
			end
			C_STATUS: begin
				out_valid = 1'b1;
				cmd.show_status = 1'b1;
				cmd.clear = out_ready;
			end
			default: begin
			end
		endcase
	end

endmodule

[design/wpc_dpath.sv]
// Parse state, sample capture, status checks and frame divider.
module wpc_dpath import wpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  cmd_t      cmd,
	output stat_t     stat,
	output out_item_t out_item
);

	phase_t      phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] len_q, len_d;
	logic [15:0] fmt_q, fmt_d;
	logic [15:0] ch_q, ch_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] align_q, align_d;
	logic [15:0] bits_q, bits_d;
	logic [31:0] dlen_q, dlen_d;
	logic [7:0]  low_q, low_d;
	logic [1:0]  seen_q, seen_d;
	logic [3:0]  err_q, err_d;
	logic        emit_q, emit_d;
	logic        start_q, start_d;
	logic [15:0] samp_q, samp_d;
	logic        eof_q;
	logic [3:0]  st_q, pre_st;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [5:0]  cnt_q;
	logic [16:0] trial;
	logic        fit;
	logic [31:0] p1;
	logic [7:0]  b;
	logic [3:0]  st_out;

	function automatic logic [31:0] put_byte(logic [31:0] w, logic [1:0] idx, logic [7:0] v);
		logic [31:0] r;
		r = w;
		r[{idx, 3'b000} +: 8] = v;
		return r;
	endfunction

	assign b = in_item.byte_value;
	assign p1 = pos_q + 32'd1;

	always_comb begin
		phase_d = phase_q; pos_d = pos_q; tag_d = tag_q; len_d = len_q;
		fmt_d = fmt_q; ch_d = ch_q; rate_d = rate_q; align_d = align_q;
		bits_d = bits_q; dlen_d = dlen_q; low_d = low_q; seen_d = seen_q;
		err_d = err_q; emit_d = 1'b0; start_d = 1'b0; samp_d = samp_q;
		case (phase_q)
			PH_HEAD: begin
				tag_d = {tag_q[23:0], b};
				if (pos_q == 32'd3 && tag_d != TAG_RIFF) begin
					if (err_q == ST_OK) err_d = ST_NO_RIFF;
					phase_d = PH_DONE;
				end else if (pos_q == 32'd11 && tag_d != TAG_WAVE) begin
					if (err_q == ST_OK) err_d = ST_NO_WAVE;
					phase_d = PH_DONE;
				end else if (p1 >= 32'd12) begin
					phase_d = PH_CHUNK;
					pos_d = '0;
				end else begin
					pos_d = p1;
				end
			end
			PH_CHUNK: begin
				if (pos_q < 32'd4) tag_d = {tag_q[23:0], b};
				else len_d = put_byte(len_q, pos_q[1:0], b);
				pos_d = p1;
				if (p1 >= 32'd8) begin
					pos_d = '0;
					if (tag_d == TAG_FMT) begin
						if (len_d < FMT_FIXED_LEN) begin
							if (err_q == ST_OK) err_d = ST_FMT_SMALL;
							phase_d = PH_DONE;
						end else begin
							phase_d = PH_FMT;
						end
					end else if (tag_d == TAG_DATA) begin
						dlen_d = len_d;
						phase_d = PH_DATA;
						if (len_d == '0) begin
							seen_d[1] = 1'b1;
							phase_d = PH_CHUNK;
						end
					end else if (len_d == '0) begin
						phase_d = PH_CHUNK;
					end else begin
						phase_d = PH_SKIP;
					end
				end
			end
			PH_FMT: begin
				if (pos_q < 32'd2) fmt_d[{pos_q[0], 3'b000} +: 8] = b;
				else if (pos_q < 32'd4) ch_d[{pos_q[0], 3'b000} +: 8] = b;
				else if (pos_q < 32'd8) rate_d = put_byte(rate_q, pos_q[1:0], b);
				else if (pos_q >= 32'd12 && pos_q < 32'd14)
					align_d[{pos_q[0], 3'b000} +: 8] = b;
				else if (pos_q >= 32'd14)
					bits_d[{pos_q[0], 3'b000} +: 8] = b;
				pos_d = p1;
				if (p1 >= FMT_FIXED_LEN) begin
					seen_d[0] = 1'b1;
					if (p1 >= len_q) begin
						phase_d = len_q[0] ? PH_PAD : PH_CHUNK;
						pos_d = '0;
					end else begin
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				pos_d = p1;
				if (p1 >= len_q) begin
					phase_d = len_q[0] ? PH_PAD : PH_CHUNK;
					pos_d = '0;
				end
			end
			PH_DATA: begin
				if (!pos_q[0]) begin
					low_d = b;
				end else begin
					emit_d = 1'b1;
					samp_d = {b, low_q};
					start_d = (pos_q == 32'd1);
				end
				pos_d = p1;
				if (p1 >= len_q) begin
					seen_d[1] = 1'b1;
					phase_d = len_q[0] ? PH_PAD : PH_CHUNK;
					pos_d = '0;
				end
			end
			PH_PAD: begin
				phase_d = PH_CHUNK;
				pos_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		pre_st = err_q;
		if (err_q == ST_OK) begin
			if (phase_q == PH_HEAD || phase_q == PH_FMT || phase_q == PH_DATA ||
			    (phase_q == PH_CHUNK && pos_q != '0))
				pre_st = ST_TRUNCATED;
			else if (seen_q != 2'b11)
				pre_st = ST_MISSING;
			else if (fmt_q != FMT_PCM || bits_q != PCM_BITS)
				pre_st = ST_UNSUPPORTED;
			else if (ch_q == '0 || rate_q == '0 || {1'b0, align_q} != {ch_q, 1'b0})
				pre_st = ST_BAD_FORMAT;
			else
				pre_st = ST_OK;
		end
	end

	assign trial = {rem_q, quo_q[31]};
	assign fit = trial >= {1'b0, align_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD; pos_q <= '0; tag_q <= '0; len_q <= '0;
			fmt_q <= '0; ch_q <= '0; rate_q <= '0; align_q <= '0; bits_q <= '0;
			dlen_q <= '0; low_q <= '0; seen_q <= '0; err_q <= '0;
			emit_q <= 1'b0; eof_q <= 1'b0; cnt_q <= '0;
		end else if (cmd.clear) begin
			phase_q <= PH_HEAD; pos_q <= '0; tag_q <= '0; len_q <= '0;
			fmt_q <= '0; ch_q <= '0; rate_q <= '0; align_q <= '0; bits_q <= '0;
			dlen_q <= '0; low_q <= '0; seen_q <= '0; err_q <= '0;
			emit_q <= 1'b0; eof_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (cmd.step) begin
				phase_q <= phase_d; pos_q <= pos_d; tag_q <= tag_d; len_q <= len_d;
				fmt_q <= fmt_d; ch_q <= ch_d; rate_q <= rate_d; align_q <= align_d;
				bits_q <= bits_d; dlen_q <= dlen_d; low_q <= low_d; seen_q <= seen_d;
				err_q <= err_d; emit_q <= emit_d; eof_q <= in_item.end_of_file;
			end
			if (cmd.div_start) cnt_q <= DIV_STEPS;
			else if (cnt_q != '0) cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			samp_q <= samp_d;
			start_q <= start_d;
		end
		if (cmd.eval) st_q <= pre_st;
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= dlen_q;
		end else if (cnt_q != '0) begin
			rem_q <= fit ? 16'(trial - {1'b0, align_q}) : trial[15:0];
			quo_q <= {quo_q[30:0], fit};
		end
	end

	assign stat.emit = emit_q;
	assign stat.eof = eof_q;
	assign stat.need_div = (pre_st == ST_OK);
	assign stat.div_done = (cnt_q == '0);

	assign st_out = (st_q == ST_OK && rem_q != '0) ? ST_UNALIGNED : st_q;

	always_comb begin
		out_item = '0;
		if (cmd.show_status) begin
			out_item.kind = 1'b1;
			out_item.status = st_out;
			out_item.channel_count = ch_q;
			out_item.rate_hz = rate_q;
			out_item.sample_bits = bits_q;
			out_item.frame_count = (st_out == ST_OK) ? quo_q[30:0] : '0;
			out_item.final_res = 1'b1;
		end else begin
			out_item.sample = samp_q;
			out_item.chunk_start = start_q;
		end
	end

endmodule

[design/wav_pcm16_chunk_parser.sv]
// Top level of the WAV PCM16 chunk parser: controller plus datapath.
//  channel | direction | payload    | handshake
//  in      | input     | in_item_t  | in_valid / in_ready
//  out     | output    | out_item_t | out_valid / out_ready
// A byte is taken while idle and then checked; when it completes a sample, the sample item waits for out_ready.
// After the final byte the status is evaluated, and the 32-step frame divider runs
// when the format checks pass, then the status item waits for out_ready.
// Reset clears all parse state; a delivered status item also clears it.
// in_ready is high only while idle: low while a byte is checked, a result waits
// or the divider runs.
module wav_pcm16_chunk_parser import wpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	cmd_t  cmd;
	stat_t stat;

	wpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	wpc_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd), .stat(stat),
		.out_item(out_item)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while a result waits");

	a_final_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_item.final_res) |=> in_ready)
		else $error("parser not free after status item");

	a_sample_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.kind) |-> (out_item.status == ST_OK && !out_item.final_res))
		else $error("sample item carries status fields");

endmodule
